[sv/frc_pkg.sv]
// Shared types, constants and helpers for the feature reference-count table.
// Used by frc_update and feature_refcount_table; depends on nothing else.
package frc_pkg;

  localparam int COUNT_W    = 16;
  localparam int MASK_W     = 16;
  localparam int FEAT_IDX_W = 4;
  localparam int IFACE_W    = 8;
  localparam int TR_W       = 3;

  localparam int DEF_NUM_INTERFACES = 256;
  localparam int DEF_NUM_FEATURES   = 16;
  localparam int DEF_COUNT_MAX      = 65535;

  typedef enum logic [TR_W-1:0] {
    TR_NONE      = 3'd0,
    TR_ENABLED   = 3'd1,
    TR_DISABLED  = 3'd2,
    TR_OVERFLOW  = 3'd3,
    TR_UNDERFLOW = 3'd4
  } transition_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK
  } state_t;

  typedef struct packed {
    logic                 wr;
    logic [COUNT_W-1:0]   count;
    transition_t          tr;
  } upd_t;

  function automatic logic [FEAT_IDX_W-1:0] lowest_set(input logic [MASK_W-1:0] m);
    logic [FEAT_IDX_W-1:0] idx;
    idx = '0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (m[i]) begin
        idx = FEAT_IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

[sv/frc_update.sv]
// Next count and reported transition for one counter, incremented or decremented.
// Depends on frc_pkg for the count width, the transition codes and upd_t.
module frc_update #(
  parameter int COUNT_MAX = frc_pkg::DEF_COUNT_MAX
) (
  input  logic [frc_pkg::COUNT_W-1:0] count,
  input  logic                        decr,
  output frc_pkg::upd_t               upd
);
  import frc_pkg::*;

  localparam logic [COUNT_W-1:0] LIMIT = COUNT_W'(COUNT_MAX);

  always_comb begin
    upd.wr    = 1'b0;
    upd.count = count;
    upd.tr    = TR_NONE;
    if (!decr) begin
      if (count >= LIMIT) begin
        upd.tr = TR_OVERFLOW;
      end else begin
        upd.wr    = 1'b1;
        upd.count = count + COUNT_W'(1);
        upd.tr    = (count == '0) ? TR_ENABLED : TR_NONE;
      end
    end else begin
      if (count == '0) begin
        upd.tr = TR_UNDERFLOW;
      end else begin
        upd.wr    = 1'b1;
        upd.count = count - COUNT_W'(1);
        upd.tr    = (count == COUNT_W'(1)) ? TR_DISABLED : TR_NONE;
      end
    end
  end

endmodule

[sv/feature_refcount_table.sv]
// Top level of the feature reference-count table: sequencer, count memory, result register.
// Depends on frc_pkg and frc_update.
//
// After reset the block clears its count memory, one entry a cycle, all
// 2**(IB+FB) entries (4096 at the default sizes), where IB and FB are the
// address bits of the interface and feature fields; requests are stalled
// until the pass ends. A request with k selected features then produces k
// results, one per cycle while the result side does not stall; the first
// count is read from the synchronous memory before it can be updated.
// A request with no usable feature gives its single result in the cycle
// after it is accepted. One request is handled at a time; each count read
// for the next feature overlaps the write-back of the current one.
module feature_refcount_table #(
  parameter int NUM_INTERFACES = frc_pkg::DEF_NUM_INTERFACES,
  parameter int NUM_FEATURES   = frc_pkg::DEF_NUM_FEATURES,
  parameter int COUNT_MAX      = frc_pkg::DEF_COUNT_MAX
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  logic                           kind,
  input  logic [frc_pkg::IFACE_W-1:0]    interface_index,
  input  logic [frc_pkg::MASK_W-1:0]     feature_mask,
  output logic                           evt_valid,
  input  logic                           evt_stall,
  output logic [frc_pkg::IFACE_W-1:0]    event_interface,
  output logic [frc_pkg::FEAT_IDX_W-1:0] event_feature,
  output logic [frc_pkg::TR_W-1:0]       transition,
  output logic                           last
);
  import frc_pkg::*;

  localparam int EFF_I = (NUM_INTERFACES > (1 << IFACE_W)) ? (1 << IFACE_W) : NUM_INTERFACES;
  localparam int EFF_F = (NUM_FEATURES > MASK_W) ? MASK_W : NUM_FEATURES;
  localparam int IB    = (EFF_I > 1) ? $clog2(EFF_I) : 1;
  localparam int FB    = (EFF_F > 1) ? $clog2(EFF_F) : 1;
  localparam int AW    = IB + FB;
  localparam int DEPTH = 1 << AW;
  localparam logic [MASK_W-1:0] FEAT_SEL =
      (EFF_F >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((MASK_W'(1) << EFF_F) - MASK_W'(1));

  logic [COUNT_W-1:0] mem [DEPTH];

  state_t                 state, state_next;
  logic [AW-1:0]          clr_addr;
  logic [MASK_W-1:0]      pending;
  logic [FEAT_IDX_W-1:0]  cur_f;
  logic [IFACE_W-1:0]     iface;
  logic                   decr;
  logic [COUNT_W-1:0]     rdata;

  logic [IFACE_W-1:0]     ev_if;
  logic [FEAT_IDX_W-1:0]  ev_f;
  logic [TR_W-1:0]        ev_tr;
  logic                   ev_last;
  logic                   ev_valid;

  logic                   in_range;
  logic [MASK_W-1:0]      req_mask;
  logic                   accept;
  logic                   out_free;
  logic                   advance;
  logic [MASK_W-1:0]      pend_rest;
  logic [FEAT_IDX_W-1:0]  next_f;
  logic [IFACE_W-1:0]     iface_sel;
  logic                   rd_en;
  logic [AW-1:0]          raddr;
  logic                   wr_en;
  logic [AW-1:0]          waddr;
  logic [COUNT_W-1:0]     wdata;
  upd_t                   upd;

  frc_update #(
    .COUNT_MAX(COUNT_MAX)
  ) u_update (
    .count(rdata),
    .decr (decr),
    .upd  (upd)
  );

  assign in_range  = ({1'b0, interface_index} < (IFACE_W + 1)'(EFF_I));
  assign req_mask  = feature_mask & FEAT_SEL & {MASK_W{in_range}};
  assign out_free  = !ev_valid || !evt_stall;
  assign req_stall = (state != ST_IDLE) || !out_free;
  assign accept    = req_valid && !req_stall;
  assign advance   = (state == ST_WALK) && out_free;
  assign pend_rest = pending & ~(MASK_W'(1) << cur_f);
  assign next_f    = lowest_set((state == ST_IDLE) ? req_mask : pend_rest);
  assign iface_sel = (state == ST_IDLE) ? interface_index : iface;

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == {AW{1'b1}}) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && (req_mask != '0)) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (advance && (pend_rest == '0)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    rd_en = 1'b0;
    raddr = {iface_sel[IB-1:0], next_f[FB-1:0]};
    wr_en = 1'b0;
    waddr = {iface[IB-1:0], cur_f[FB-1:0]};
    wdata = upd.count;
    case (state)
      ST_CLEAR: begin
        wr_en = 1'b1;
        waddr = clr_addr;
        wdata = '0;
      end
      ST_IDLE: begin
        rd_en = accept && (req_mask != '0);
      end
      ST_WALK: begin
        rd_en = advance && (pend_rest != '0);
        wr_en = advance && upd.wr;
      end
      default: begin
        rd_en = 1'b0;
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      pending  <= '0;
      ev_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (accept) begin
        pending <= req_mask;
      end else if (advance) begin
        pending <= pend_rest;
      end
      if ((accept && (req_mask == '0)) || advance) begin
        ev_valid <= 1'b1;
      end else if (!evt_stall) begin
        ev_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      iface <= interface_index;
      decr  <= kind;
      cur_f <= next_f;
    end else if (advance) begin
      cur_f <= next_f;
    end
    if (accept && (req_mask == '0)) begin
      ev_if   <= interface_index;
      ev_f    <= '0;
      ev_tr   <= TR_NONE;
      ev_last <= 1'b1;
    end else if (advance) begin
      ev_if   <= iface;
      ev_f    <= cur_f;
      ev_tr   <= upd.tr;
      ev_last <= (pend_rest == '0);
    end
  end

  assign evt_valid       = ev_valid;
  assign event_interface = ev_if;
  assign event_feature   = ev_f;
  assign transition      = ev_tr;
  assign last            = ev_last;

endmodule
